// File: rtl/bfa_pkg.sv
// Shared types, codes and defaults for the bitmap frame allocator.
// No dependencies; bfa_ctrl, the top level and the testbench import it, bfa_map_ram does not.
package bfa_pkg;

  localparam int DEF_MAX_FRAMES    = 32768;
  localparam int DEF_PAGE_SHIFT    = 12;
  localparam int DEF_MAP_WORD_BITS = 32;

  localparam int ADDR_W  = 32;
  localparam int PAGES_W = 16;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE     = 2'd2;
  localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 1'b1;

  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   frame_addr;
    logic [STAT_W-1:0]   status;
    logic [PAGES_W-1:0]  free_frames;
  } bfa_res_t;

endpackage

// File: rtl/bfa_map_ram.sv
// Single-port-write, single-port-read bitmap memory, registered read data.
// Depends on nothing but its parameters.
module bfa_map_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bfa_ctrl.sv
// Request sequencer: decode, next-fit word scan, free check, reset and clear sweeps.
// Depends on bfa_pkg; drives the bitmap memory ports of bfa_map_ram.
module bfa_ctrl
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
  parameter int PAGE_SHIFT    = DEF_PAGE_SHIFT,
  parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS,
  parameter int MAP_WORDS     = MAX_FRAMES / MAP_WORD_BITS,
  parameter int AW            = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start_i,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic [ADDR_W-1:0]        free_addr_i,
  input  logic [ADDR_W-1:0]        pool_base_i,
  input  logic [PAGES_W-1:0]       pool_pages_i,
  output logic                     idle_o,
  input  logic                     res_ready_i,
  output bfa_res_t                 res_o,
  output logic                     map_we_o,
  output logic [AW-1:0]            map_waddr_o,
  output logic [MAP_WORD_BITS-1:0] map_wdata_o,
  output logic                     map_re_o,
  output logic [AW-1:0]            map_raddr_o,
  input  logic [MAP_WORD_BITS-1:0] map_rdata_i
);

  localparam int BW = $clog2(MAP_WORD_BITS);
  localparam int IW = $clog2(MAX_FRAMES);
  localparam int CW = IW + 1;
  localparam int KW = $clog2(MAP_WORDS + 1);
  localparam int XW = ADDR_W - PAGE_SHIFT;
  localparam logic [AW-1:0]            LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [BW-1:0]            LAST_BIT  = BW'(MAP_WORD_BITS - 1);
  localparam logic [KW-1:0]            LAST_CNT  = KW'(MAP_WORDS);
  localparam logic [MAP_WORD_BITS-1:0] ONES      = '1;
  localparam logic [PAGES_W:0]         MAXF_EXT  = (PAGES_W + 1)'(MAX_FRAMES);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_FCHK   = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  function automatic logic [BW-1:0] lowest_one(input logic [MAP_WORD_BITS-1:0] v);
    logic [BW-1:0] p;
    p = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (v[j]) p = BW'(j);
    end
    return p;
  endfunction

  function automatic logic [AW-1:0] word_inc(input logic [AW-1:0] w);
    return (w == LAST_WORD) ? '0 : AW'(w + 1'b1);
  endfunction

  state_t               state_r, state_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]        word_r, word_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;
  logic [KW-1:0]        cnt_r, cnt_nxt;
  logic                 first_r, first_nxt;
  logic [AW-1:0]        nword_r, nword_nxt;
  logic [BW-1:0]        nbit_r, nbit_nxt;
  logic [PAGES_W-1:0]   free_total_r, free_total_nxt;
  logic [CW-1:0]        pool_size_r, pool_size_nxt;
  logic [CW-1:0]        fill_n_r, fill_n_nxt;
  logic [ADDR_W-1:0]    frame_r, frame_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;

  logic [ADDR_W-1:0]        off;
  logic [XW-1:0]            fidx;
  logic [CW-1:0]            n_sat;
  logic [CW-1:0]            lo;
  logic [CW-1:0]            diff;
  logic [MAP_WORD_BITS-1:0] fill_word;
  logic [MAP_WORD_BITS-1:0] mask;
  logic [MAP_WORD_BITS-1:0] avail;
  logic [BW-1:0]            hit;
  logic [IW-1:0]            flat;

  always_comb begin
    off   = addr_r - pool_base_i;
    fidx  = off[ADDR_W-1:PAGE_SHIFT];
    n_sat = ({1'b0, pool_pages_i} >= MAXF_EXT) ? CW'(MAX_FRAMES) : CW'(pool_pages_i);
    lo    = CW'(word_r) << BW;
    diff  = fill_n_r - lo;
    if (fill_n_r <= lo) begin
      fill_word = ONES;
    end else if (fill_n_r >= lo + CW'(MAP_WORD_BITS)) begin
      fill_word = '0;
    end else begin
      fill_word = ONES << diff[BW-1:0];
    end
    mask  = first_r ? (ONES << nbit_r) : ONES;
    avail = ~map_rdata_i & mask;
    hit   = lowest_one(avail);
    flat  = (IW'(word_r) << BW) | IW'(hit);
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    word_nxt       = word_r;
    bit_nxt        = bit_r;
    cnt_nxt        = cnt_r;
    first_nxt      = first_r;
    nword_nxt      = nword_r;
    nbit_nxt       = nbit_r;
    free_total_nxt = free_total_r;
    pool_size_nxt  = pool_size_r;
    fill_n_nxt     = fill_n_r;
    frame_nxt      = frame_r;
    status_nxt     = status_r;
    map_we_o       = 1'b0;
    map_waddr_o    = word_r;
    map_wdata_o    = fill_word;
    map_re_o       = 1'b0;
    map_raddr_o    = word_r;

    unique case (state_r)
      S_INIT, S_CLEAR: begin
        map_we_o = 1'b1;
        word_nxt = word_inc(word_r);
        if (word_r == LAST_WORD) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          req_nxt   = req_type_i;
          addr_nxt  = free_addr_i;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        frame_nxt  = '0;
        status_nxt = ST_OK;
        priority case (req_r)
          REQ_ALLOC: begin
            if (free_total_r == '0) begin
              status_nxt = ST_EXHAUSTED;
              state_nxt  = S_DONE;
            end else begin
              map_re_o    = 1'b1;
              map_raddr_o = nword_r;
              word_nxt    = nword_r;
              cnt_nxt     = '0;
              first_nxt   = 1'b1;
              state_nxt   = S_SCAN;
            end
          end
          REQ_FREE: begin
            if (ADDR_W'(fidx) >= ADDR_W'(pool_size_r)) begin
              status_nxt = ST_OUTSIDE;
              state_nxt  = S_DONE;
            end else begin
              map_re_o    = 1'b1;
              map_raddr_o = AW'(fidx >> BW);
              word_nxt    = AW'(fidx >> BW);
              bit_nxt     = fidx[BW-1:0];
              state_nxt   = S_FCHK;
            end
          end
          REQ_CLEAR: begin
            fill_n_nxt     = n_sat;
            pool_size_nxt  = n_sat;
            free_total_nxt = PAGES_W'(n_sat);
            nword_nxt      = '0;
            nbit_nxt       = '0;
            word_nxt       = '0;
            state_nxt      = S_CLEAR;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (avail != '0) begin
          map_we_o       = 1'b1;
          map_wdata_o    = map_rdata_i | (MAP_WORD_BITS'(1) << hit);
          free_total_nxt = free_total_r - 1'b1;
          frame_nxt      = pool_base_i + (ADDR_W'(flat) << PAGE_SHIFT);
          if (hit == LAST_BIT) begin
            nbit_nxt  = '0;
            nword_nxt = word_inc(word_r);
          end else begin
            nbit_nxt  = hit + 1'b1;
            nword_nxt = word_r;
          end
          state_nxt = S_DONE;
        end else if (cnt_r == LAST_CNT) begin
          status_nxt = ST_EXHAUSTED;
          state_nxt  = S_DONE;
        end else begin
          map_re_o    = 1'b1;
          map_raddr_o = word_inc(word_r);
          word_nxt    = word_inc(word_r);
          cnt_nxt     = cnt_r + 1'b1;
          first_nxt   = 1'b0;
        end
      end
      S_FCHK: begin
        if (!map_rdata_i[bit_r]) begin
          status_nxt = ST_DOUBLE_FREE;
        end else begin
          map_we_o       = 1'b1;
          map_wdata_o    = map_rdata_i & ~(MAP_WORD_BITS'(1) << bit_r);
          free_total_nxt = free_total_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      word_r       <= '0;
      fill_n_r     <= '0;
      nword_r      <= '0;
      nbit_r       <= '0;
      free_total_r <= '0;
      pool_size_r  <= '0;
      cnt_r        <= '0;
      first_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      word_r       <= word_nxt;
      fill_n_r     <= fill_n_nxt;
      nword_r      <= nword_nxt;
      nbit_r       <= nbit_nxt;
      free_total_r <= free_total_nxt;
      pool_size_r  <= pool_size_nxt;
      cnt_r        <= cnt_nxt;
      first_r      <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    addr_r   <= addr_nxt;
    bit_r    <= bit_nxt;
    frame_r  <= frame_nxt;
    status_r <= status_nxt;
  end

  assign idle_o            = (state_r == S_IDLE);
  assign res_o.valid       = (state_r == S_DONE);
  assign res_o.frame_addr  = frame_r;
  assign res_o.status      = status_r;
  assign res_o.free_frames = free_total_r;

endmodule

// File: rtl/bitmap_frame_allocator_unit.sv
// Top level of the bitmap frame allocator: config registers, output word register.
// Depends on bfa_pkg, bfa_ctrl and bfa_map_ram.
//
//   port group  direction  flow control     word contents
//   in_*        input      in_valid/stall   req_type, free_addr
//   out_*       output     out_valid/stall  frame_addr, status, free_frames
//   cfg_*       input      cfg_wr_en        cfg_index, cfg_data
//
// One request at a time. A free inside the pool is decoded, then its bitmap word is read,
// checked and, unless the frame is already free, written back; unknown requests, a free
// outside the pool and an allocate on an empty count go from decode to the result.
// Allocate reads bitmap words from the next-fit position on, one word per cycle through
// the single read port. Clear writes one bitmap word per cycle over the whole map.
// After reset a sweep over all MAP_WORDS bitmap words (1024 by default) marks all frames
// used; in_stall stays high until it ends. A stalled result holds in the output
// register while the next request is accepted and worked on.
module bitmap_frame_allocator_unit
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
  parameter int PAGE_SHIFT    = DEF_PAGE_SHIFT,
  parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [ADDR_W-1:0]    in_free_addr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    out_frame_addr,
  output logic [STAT_W-1:0]    out_status,
  output logic [PAGES_W-1:0]   out_free_frames,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int MAP_WORDS = MAX_FRAMES / MAP_WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [ADDR_W-1:0]  pool_base_r, pool_base_nxt;
  logic [PAGES_W-1:0] pool_pages_r, pool_pages_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  frame_r;
  logic [STAT_W-1:0]  status_r;
  logic [PAGES_W-1:0] free_frames_r;

  logic                     ctrl_idle;
  logic                     res_ready;
  bfa_res_t                 res;
  logic                     map_we;
  logic [AW-1:0]            map_waddr;
  logic [MAP_WORD_BITS-1:0] map_wdata;
  logic                     map_re;
  logic [AW-1:0]            map_raddr;
  logic [MAP_WORD_BITS-1:0] map_rdata;

  assign in_stall  = !ctrl_idle;
  assign res_ready = !out_valid_r || !out_stall;

  bfa_ctrl #(
    .MAX_FRAMES    (MAX_FRAMES),
    .PAGE_SHIFT    (PAGE_SHIFT),
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .MAP_WORDS     (MAP_WORDS),
    .AW            (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (in_valid && ctrl_idle),
    .req_type_i   (in_req_type),
    .free_addr_i  (in_free_addr),
    .pool_base_i  (pool_base_r),
    .pool_pages_i (pool_pages_r),
    .idle_o       (ctrl_idle),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .map_we_o     (map_we),
    .map_waddr_o  (map_waddr),
    .map_wdata_o  (map_wdata),
    .map_re_o     (map_re),
    .map_raddr_o  (map_raddr),
    .map_rdata_i  (map_rdata)
  );

  bfa_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (MAP_WORD_BITS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  always_comb begin
    pool_base_nxt  = pool_base_r;
    pool_pages_nxt = pool_pages_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POOL_BASE:  pool_base_nxt  = cfg_data;
        CFG_POOL_PAGES: pool_pages_nxt = cfg_data[PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= '0;
      pool_pages_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pool_base_r  <= pool_base_nxt;
      pool_pages_r <= pool_pages_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      frame_r       <= res.frame_addr;
      status_r      <= res.status;
      free_frames_r <= res.free_frames;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_addr  = frame_r;
  assign out_status      = status_r;
  assign out_free_frames = free_frames_r;

`ifndef NO_ASSERTIONS
  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_frame_addr == '0)
    else $error("frame address on a failed request");

  a_exhausted_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EXHAUSTED |-> out_free_frames == '0)
    else $error("pool exhausted with free frames left");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_free_frames} <= (PAGES_W + 1)'(MAX_FRAMES))
    else $error("free count above pool capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");
`endif

endmodule

// File: sim/bitmap_frame_allocator_unit_tb.sv
// Self-checking testbench for bitmap_frame_allocator_unit: directed table, then random phases.
// Expected words come from typed table rows, else from an in-bench next-fit allocator predictor; depends on bfa_pkg.
module bitmap_frame_allocator_unit_tb;
  import bfa_pkg::*;

  localparam int FRAMES       = DEF_MAX_FRAMES;
  localparam int PAGE_SHIFT   = DEF_PAGE_SHIFT;
  localparam int PAGE_MASK    = (1 << PAGE_SHIFT) - 1;
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_ITEMS  = 150;
  localparam int STUCK_LIMIT  = 8000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PLAN_ROWS    = 33;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  frame_addr;
    logic [STAT_W-1:0]  status;
    logic [PAGES_W-1:0] free_frames;
  } alloc_word_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [REQ_W-1:0]     req;
    logic [ADDR_W-1:0]    data;
    logic                 typed;
    logic [ADDR_W-1:0]    want_addr;
    logic [STAT_W-1:0]    want_status;
    logic [PAGES_W-1:0]   want_free;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     in_req_type = '0;
  logic [ADDR_W-1:0]    in_free_addr = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    out_frame_addr;
  logic [STAT_W-1:0]    out_status;
  logic [PAGES_W-1:0]   out_free_frames;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  bit                frame_busy [FRAMES];
  int unsigned       fit_ptr;
  int unsigned       free_count;
  int unsigned       pool_frames;
  logic [ADDR_W-1:0] base_reg;
  logic [PAGES_W-1:0] pages_reg;
  int unsigned       live_frames [$];

  alloc_word_t awaited_results [$];
  int          mismatches;
  int          checked;
  int          words_sent;
  int          random_sent;
  int          settings_count;
  int          status_seen [4];
  int          stuck_cycles;
  int          stall_left;
  bit          cfg_open;
  bit          idle_on = 1'b1;
  bit          quiet_tail;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{1'b0, CFG_POOL_BASE, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EXHAUSTED, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OUTSIDE, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK, 16'd0},
    '{1'b1, CFG_POOL_BASE, REQ_ALLOC, 32'hFFFF_F000, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b1, CFG_POOL_PAGES, REQ_ALLOC, 32'h0000_0003, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_CLEAR, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK, 16'd3},
    '{1'b0, CFG_POOL_BASE, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'hFFFF_F000, ST_OK, 16'd2},
    '{1'b0, CFG_POOL_BASE, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK, 16'd1},
    '{1'b0, CFG_POOL_BASE, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_1000, ST_OK, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EXHAUSTED, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'h0000_0FFF, 1'b1, 32'h0000_0000, ST_OK, 16'd1},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'h0000_1234, 1'b1, 32'h0000_0000, ST_OK, 16'd2},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_DOUBLE_FREE, 16'd2},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'h0000_2000, 1'b1, 32'h0000_0000, ST_OUTSIDE, 16'd2},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'hFFFF_EFFF, 1'b1, 32'h0000_0000, ST_OUTSIDE, 16'd2},
    '{1'b0, CFG_POOL_BASE, REQ_ALLOC, 32'hA5A5_5A5A, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b1, CFG_POOL_BASE, REQ_ALLOC, 32'h0000_0000, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b1, CFG_POOL_PAGES, REQ_ALLOC, 32'h0000_FFFF, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK, 16'd32768},
    '{1'b0, CFG_POOL_BASE, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK, 16'd32767},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'h07FF_F000, 1'b1, 32'h0000_0000, ST_DOUBLE_FREE,
      16'd32767},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'h0800_0000, 1'b1, 32'h0000_0000, ST_OUTSIDE, 16'd32767},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'h0000_0ABC, 1'b1, 32'h0000_0000, ST_OK, 16'd32768},
    '{1'b1, CFG_POOL_BASE, REQ_ALLOC, 32'h1234_5000, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b1, CFG_POOL_PAGES, REQ_ALLOC, 32'h0000_8000, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_CLEAR, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK, 16'd32768},
    '{1'b0, CFG_POOL_BASE, REQ_FREE, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b1, CFG_POOL_PAGES, REQ_ALLOC, 32'h0000_0001, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_CLEAR, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK, 16'd1},
    '{1'b0, CFG_POOL_BASE, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h1234_5000, ST_OK, 16'd0},
    '{1'b1, CFG_POOL_PAGES, REQ_ALLOC, 32'h0000_0000, 1'b0, 32'h0, ST_OK, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_CLEAR, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK, 16'd0},
    '{1'b0, CFG_POOL_BASE, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EXHAUSTED, 16'd0}
  };

  bitmap_frame_allocator_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_free_addr    (in_free_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_addr  (out_frame_addr),
    .out_status      (out_status),
    .out_free_frames (out_free_frames),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alloc_word_t next_fit_outcome(input logic [REQ_W-1:0] req,
                                                   input logic [ADDR_W-1:0] addr);
    alloc_word_t       res;
    int unsigned       idx;
    int unsigned       n;
    int unsigned       span;
    logic [ADDR_W-1:0] off;
    bit                found;
    res = '0;
    res.status = ST_OK;
    case (req)
      REQ_ALLOC: begin
        if (free_count == 0) begin
          res.status = ST_EXHAUSTED;
        end else begin
          idx = fit_ptr;
          found = 1'b0;
          for (n = 0; n < FRAMES && !found; n++) begin
            if (!frame_busy[idx]) found = 1'b1;
            else idx = (idx + 1) % FRAMES;
          end
          if (found) begin
            frame_busy[idx] = 1'b1;
            free_count--;
            fit_ptr = (idx + 1) % FRAMES;
            res.frame_addr = base_reg + (idx << PAGE_SHIFT);
            live_frames.push_back(idx);
          end else begin
            res.status = ST_EXHAUSTED;
          end
        end
      end
      REQ_FREE: begin
        off = addr - base_reg;
        idx = off >> PAGE_SHIFT;
        if (idx >= pool_frames) begin
          res.status = ST_OUTSIDE;
        end else if (!frame_busy[idx]) begin
          res.status = ST_DOUBLE_FREE;
        end else begin
          frame_busy[idx] = 1'b0;
          free_count++;
          n = 0;
          while (n < live_frames.size() && live_frames[n] != idx) n++;
          if (n < live_frames.size()) live_frames.delete(n);
        end
      end
      REQ_CLEAR: begin
        span = (pages_reg > FRAMES) ? FRAMES : pages_reg;
        foreach (frame_busy[i]) frame_busy[i] = (i >= span);
        pool_frames = span;
        free_count = span;
        fit_ptr = 0;
        live_frames.delete();
      end
      default: begin
      end
    endcase
    res.free_frames = free_count[PAGES_W-1:0];
    status_seen[res.status]++;
    return res;
  endfunction

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    if (!cfg_open) begin
      in_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
      cfg_open = 1'b1;
    end
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CFG_POOL_BASE) base_reg = value;
    else pages_reg = value[PAGES_W-1:0];
  endtask

  task automatic send_word(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                           input logic typed, input alloc_word_t want);
    alloc_word_t outcome;
    if (cfg_open) begin
      cfg_wr_en <= 1'b0;
      cfg_open = 1'b0;
    end
    if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_req_type <= req;
    in_free_addr <= addr;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    outcome = next_fit_outcome(req, addr);
    awaited_results.push_back(typed ? want : outcome);
    words_sent++;
  endtask

  task automatic run_random_phase();
    int unsigned       shape;
    int unsigned       n_items;
    int unsigned       k;
    int unsigned       pick;
    int unsigned       idx;
    int unsigned       offset;
    logic [ADDR_W-1:0] addr;
    logic [PAGES_W-1:0] pages;
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      pages = 16'($urandom_range(1, 8));
      n_items = $urandom_range(15, 35);
    end else if (shape == 2) begin
      pages = 16'(FRAMES);
      n_items = $urandom_range(40, 90);
    end else if (shape == 3) begin
      pages = '0;
      n_items = $urandom_range(5, 12);
    end else begin
      pages = 16'($urandom_range(16, 400));
      n_items = $urandom_range(30, 90);
    end
    case ($urandom_range(0, 3))
      0: reg_write(CFG_POOL_BASE, 32'hFFFF_F000);
      1: reg_write(CFG_POOL_BASE, $urandom & 32'hFFFF_F000);
      2: reg_write(CFG_POOL_BASE, $urandom_range(0, 32'hFFFF_F000));
      default: begin
      end
    endcase
    reg_write(CFG_POOL_PAGES, {16'h0, pages});
    settings_count++;
    idle_on = ($urandom_range(0, 2) != 0);
    send_word(REQ_CLEAR, $urandom, 1'b0, '0);
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      offset = $urandom_range(0, PAGE_MASK);
      if (pick >= 48 && pick < 83 && live_frames.size() != 0) begin
        idx = live_frames[$urandom_range(0, live_frames.size() - 1)];
        send_word(REQ_FREE, base_reg + (idx << PAGE_SHIFT) + offset, 1'b0, '0);
      end else if (pick >= 83 && pick < 88 && pool_frames != 0) begin
        idx = $urandom_range(0, pool_frames - 1);
        send_word(REQ_FREE, base_reg + (idx << PAGE_SHIFT) + offset, 1'b0, '0);
      end else if (pick >= 88 && pick < 93) begin
        if ($urandom_range(0, 1) == 0)
          addr = base_reg + ((pool_frames + $urandom_range(0, 3)) << PAGE_SHIFT) + offset;
        else
          addr = base_reg - $urandom_range(1, 32'h0010_0000);
        send_word(REQ_FREE, addr, 1'b0, '0);
      end else if (pick >= 93 && pick < 96) begin
        send_word(REQ_UNKNOWN, $urandom, 1'b0, '0);
      end else if (pick >= 96 && pick < 98) begin
        send_word(REQ_FREE, $urandom, 1'b0, '0);
      end else if (pick >= 98) begin
        send_word(REQ_CLEAR, $urandom, 1'b0, '0);
      end else begin
        send_word(REQ_ALLOC, $urandom, 1'b0, '0);
      end
      random_sent++;
      quiet_tail = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_words
    alloc_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected word frame_addr %h status %0d free_frames %0d", $time,
                 out_frame_addr, out_status, out_free_frames);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        checked++;
        if (out_frame_addr !== want.frame_addr) begin
          $display("%0t: frame_addr expected %h actual %h", $time, want.frame_addr,
                   out_frame_addr);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatches++;
        end
        if (out_free_frames !== want.free_frames) begin
          $display("%0t: free_frames expected %0d actual %0d", $time, want.free_frames,
                   out_free_frames);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        cfg_wr_en) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words outstanding", $time,
               stuck_cycles, awaited_results.size());
      $display("bitmap_frame_allocator_unit verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    alloc_word_t row_want;
    foreach (frame_busy[i]) frame_busy[i] = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_plan[r]) begin
      if (directed_plan[r].is_cfg) begin
        reg_write(directed_plan[r].reg_idx, directed_plan[r].data);
      end else begin
        row_want.frame_addr = directed_plan[r].want_addr;
        row_want.status = directed_plan[r].want_status;
        row_want.free_frames = directed_plan[r].want_free;
        send_word(directed_plan[r].req, directed_plan[r].data, directed_plan[r].typed,
                  row_want);
      end
    end
    while (random_sent < RANDOM_ITEMS) run_random_phase();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d request words over %0d random pool settings, checked %0d results.",
             words_sent, settings_count, checked);
    $display("Outcomes: %0d ok, %0d exhausted, %0d outside pool, %0d double free.",
             status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_OUTSIDE],
             status_seen[ST_DOUBLE_FREE]);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("bitmap_frame_allocator_unit verification clean");
    else
      $display("bitmap_frame_allocator_unit verification failed");
    $finish;
  end

endmodule
